@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion on the default clock and reset names of this project.
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ design/rgbcc_pkg.sv @@
package rgbcc_pkg;

   // field widths
   localparam int RAW_W   = 10;
   localparam int OFS_W   = 11;
   localparam int SCL_W   = 10;
   localparam int TOL_W   = 8;
   localparam int REF_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int IDX_W   = 3;
   localparam int MAX_COLORS = 6;

   // register indexes
   localparam logic [IDX_W-1:0] REG_TOLERANCE   = 3'd0;
   localparam logic [IDX_W-1:0] REG_REF_COLOR_0 = 3'd1;

   // reset values
   localparam logic [TOL_W-1:0] TOL_RESET = 8'd8;
   localparam logic [REF_W-1:0] REF_RESET [MAX_COLORS] = '{
      24'hB2B2B4, 24'hE7C9EF, 24'hCBC3B4, 24'hB1B7DF, 24'hB5D9F6, 24'hF2D5BD
   };

   // floor(s / 3) = (s * 2731) >> 13 for every sum of three readings (s < 3070)
   localparam logic [11:0] MEAN_RECIP = 12'd2731;
   localparam int          MEAN_SHIFT = 13;

   // floor(m * 255 / 1023) = (m * 16728085) >> 26 for m < 2047
   localparam logic [23:0] SCALE_RECIP = 24'd16728085;
   localparam int          SCALE_SHIFT = 26;

endpackage

@@ design/rgb_color_calibrate_classify_top.sv @@
// Colour sensor front end: white balance and tolerance match.
//
// Input channel (req_): one raw red/green/blue reading per word. The first word
// accepted after reset is the white calibration; it stores the three channel
// offsets (mean minus channel) and its result carries them with
// rsp_was_calibration high, zero scaled values and an empty match mask.
// Every later word adds the offsets, scales by 255/1023 (towards zero) and
// sets bit i of rsp_match_mask when all three scaled values lie strictly
// within the tolerance of reference colour i.
// Result channel (rsp_): one word per input word, in order.
// Register port (csr_): tolerance at index 0, reference colours from index 1;
// write only while no word is in flight.
// Each accepted word passes the input register, then the result register;
// rsp_valid rises once it is in the result register.
// Throughput: one word per cycle while rsp_ready stays high, set by the single
// scale-and-compare pass between the two registers.
// Reset clears both stages, the calibration flag and the offsets, and loads
// the default tolerance and reference colours.
// When the receiver stalls, the result register holds its word and the input
// register takes one more; req_ready then falls until rsp_ready returns.
module rgb_color_calibrate_classify_top #(
   parameter int NUM_COLORS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rgbcc_pkg::RAW_W-1:0]        req_raw_red,
   input  logic [rgbcc_pkg::RAW_W-1:0]        req_raw_green,
   input  logic [rgbcc_pkg::RAW_W-1:0]        req_raw_blue,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_was_calibration,
   output logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_red,
   output logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_green,
   output logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_blue,
   output logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_red,
   output logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_green,
   output logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_blue,
   output logic [NUM_COLORS-1:0]              rsp_match_mask,
   // register port
   input  logic                               csr_we,
   input  logic [rgbcc_pkg::IDX_W-1:0]        csr_index,
   input  logic [rgbcc_pkg::REF_W-1:0]        csr_wdata
);

   localparam int RW = rgbcc_pkg::RAW_W;
   localparam int OW = rgbcc_pkg::OFS_W;
   localparam int SW = rgbcc_pkg::SCL_W;
   localparam int CW = rgbcc_pkg::CHAN_W;

   // configuration registers
   logic [rgbcc_pkg::TOL_W-1:0] tol_ff;
   logic [rgbcc_pkg::REF_W-1:0] ref_ff [NUM_COLORS];

   // calibration state
   logic          calibrated_ff, calibrated_in;
   logic [OW-1:0] ofs_r_ff, ofs_g_ff, ofs_b_ff;

   // input register
   logic          s1_vld_ff, s1_vld_in;
   logic          s1_cal_ff;
   logic [RW-1:0] s1_r_ff, s1_g_ff, s1_b_ff;

   // result register
   logic            out_vld_ff, out_vld_in;
   logic            out_cal_ff;
   logic [OW-1:0]   out_ofs_r_ff, out_ofs_g_ff, out_ofs_b_ff;
   logic [SW-1:0]   out_scl_r_ff, out_scl_g_ff, out_scl_b_ff;
   logic [NUM_COLORS-1:0] out_mask_ff;

   // handshake
   logic req_fire, out_open, s1_move;

   assign out_open  = !out_vld_ff || rsp_ready;
   assign s1_move   = s1_vld_ff && out_open;
   assign req_ready = !s1_vld_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   assign calibrated_in = calibrated_ff || req_fire;
   assign s1_vld_in     = req_fire || (s1_vld_ff && !s1_move);
   assign out_vld_in    = s1_move || (out_vld_ff && !rsp_ready);

   // calibration arithmetic: mean of the three readings and the offsets
   logic [11:0]   cal_sum;
   logic [23:0]   cal_prod;
   logic [RW-1:0] cal_mean;
   logic [OW-1:0] cal_ofs_r, cal_ofs_g, cal_ofs_b;

   always_comb begin
      cal_sum   = {2'b00, s1_r_ff} + {2'b00, s1_g_ff} + {2'b00, s1_b_ff};
      cal_prod  = {12'd0, cal_sum} * {12'd0, rgbcc_pkg::MEAN_RECIP};
      cal_mean  = cal_prod[rgbcc_pkg::MEAN_SHIFT +: RW];
      cal_ofs_r = {1'b0, cal_mean} - {1'b0, s1_r_ff};
      cal_ofs_g = {1'b0, cal_mean} - {1'b0, s1_g_ff};
      cal_ofs_b = {1'b0, cal_mean} - {1'b0, s1_b_ff};
   end

   // corrected value times 255/1023, truncated towards zero
   function automatic logic [SW-1:0] scale_chan(input logic [RW-1:0] raw,
                                                input logic [OW-1:0] ofs);
      logic [OW:0]   sum;
      logic [OW-1:0] mag;
      logic [34:0]   prod;
      logic [SW-1:0] quo;
      sum  = {2'b00, raw} + {ofs[OW-1], ofs};
      mag  = sum[OW] ? OW'(~sum + 1'b1) : sum[OW-1:0];
      prod = {24'd0, mag} * {11'd0, rgbcc_pkg::SCALE_RECIP};
      quo  = {1'b0, prod[rgbcc_pkg::SCALE_SHIFT +: SW-1]};
      return sum[OW] ? (~quo + 1'b1) : quo;
   endfunction

   // strict distance test of one channel against a reference byte
   function automatic logic chan_near(input logic [SW-1:0] scl,
                                      input logic [CW-1:0] refc,
                                      input logic [rgbcc_pkg::TOL_W-1:0] tol);
      logic [SW:0] diff;
      logic [SW:0] adiff;
      diff  = {scl[SW-1], scl} - {3'b000, refc};
      adiff = diff[SW] ? (~diff + 1'b1) : diff;
      return adiff < {3'b000, tol};
   endfunction

   logic [SW-1:0]         scl_r, scl_g, scl_b;
   logic [NUM_COLORS-1:0] mask_c;

   always_comb begin
      scl_r = scale_chan(s1_r_ff, ofs_r_ff);
      scl_g = scale_chan(s1_g_ff, ofs_g_ff);
      scl_b = scale_chan(s1_b_ff, ofs_b_ff);
      for (int i = 0; i < NUM_COLORS; i++) begin
         mask_c[i] = chan_near(scl_r, ref_ff[i][23:16], tol_ff) &&
                     chan_near(scl_g, ref_ff[i][15:8],  tol_ff) &&
                     chan_near(scl_b, ref_ff[i][7:0],   tol_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         calibrated_ff <= 1'b0;
         s1_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         ofs_r_ff      <= '0;
         ofs_g_ff      <= '0;
         ofs_b_ff      <= '0;
      end else begin
         calibrated_ff <= calibrated_in;
         s1_vld_ff     <= s1_vld_in;
         out_vld_ff    <= out_vld_in;
         if (s1_move && s1_cal_ff) begin
            ofs_r_ff <= cal_ofs_r;
            ofs_g_ff <= cal_ofs_g;
            ofs_b_ff <= cal_ofs_b;
         end
      end
   end

   // register port
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= rgbcc_pkg::TOL_RESET;
         for (int i = 0; i < NUM_COLORS; i++) begin
            ref_ff[i] <= rgbcc_pkg::REF_RESET[i];
         end
      end else if (csr_we) begin
         if (csr_index == rgbcc_pkg::REG_TOLERANCE) begin
            tol_ff <= csr_wdata[rgbcc_pkg::TOL_W-1:0];
         end
         for (int i = 0; i < NUM_COLORS; i++) begin
            if (csr_index == rgbcc_pkg::IDX_W'(rgbcc_pkg::REG_REF_COLOR_0 + i)) begin
               ref_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cal_ff <= !calibrated_ff;
         s1_r_ff   <= req_raw_red;
         s1_g_ff   <= req_raw_green;
         s1_b_ff   <= req_raw_blue;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_cal_ff <= s1_cal_ff;
         if (s1_cal_ff) begin
            out_ofs_r_ff <= cal_ofs_r;
            out_ofs_g_ff <= cal_ofs_g;
            out_ofs_b_ff <= cal_ofs_b;
            out_scl_r_ff <= '0;
            out_scl_g_ff <= '0;
            out_scl_b_ff <= '0;
            out_mask_ff  <= '0;
         end else begin
            out_ofs_r_ff <= ofs_r_ff;
            out_ofs_g_ff <= ofs_g_ff;
            out_ofs_b_ff <= ofs_b_ff;
            out_scl_r_ff <= scl_r;
            out_scl_g_ff <= scl_g;
            out_scl_b_ff <= scl_b;
            out_mask_ff  <= mask_c;
         end
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_was_calibration = out_cal_ff;
   assign rsp_offset_red      = out_ofs_r_ff;
   assign rsp_offset_green    = out_ofs_g_ff;
   assign rsp_offset_blue     = out_ofs_b_ff;
   assign rsp_scaled_red      = out_scl_r_ff;
   assign rsp_scaled_green    = out_scl_g_ff;
   assign rsp_scaled_blue     = out_scl_b_ff;
   assign rsp_match_mask      = out_mask_ff;

endmodule

@@ design/rgbcc_checker.sv @@
`include "assert_macros.svh"

module rgbcc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_was_calibration,
   input logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_red,
   input logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_green,
   input logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_blue,
   input logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_red
);

   // offsets seen on the calibration word
   logic                         seen_cal_ff;
   logic [rgbcc_pkg::OFS_W-1:0]  cal_r_ff, cal_g_ff, cal_b_ff;
   logic                         cal_taken;

   assign cal_taken = rsp_valid && rsp_ready && rsp_was_calibration;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_cal_ff <= 1'b0;
      end else if (cal_taken) begin
         seen_cal_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cal_taken) begin
         cal_r_ff <= rsp_offset_red;
         cal_g_ff <= rsp_offset_green;
         cal_b_ff <= rsp_offset_blue;
      end
   end

   // a stalled result word stays valid; its calibration flag and red fields hold
   `ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset_red) && $stable(rsp_scaled_red) && $stable(rsp_was_calibration), "result word changed while stalled")

   // an empty result register never blocks the input
   `ASSERT_STD(a_ready_when_empty, !rsp_valid |-> req_ready, "input blocked with empty output")

   // exactly one calibration word, and it comes first
   `ASSERT_STD(a_cal_order, rsp_valid |-> (rsp_was_calibration != seen_cal_ff), "calibration word out of order")

   // measurements report the offsets set by calibration
   `ASSERT_STD(a_ofs_kept, rsp_valid && !rsp_was_calibration |-> rsp_offset_red == cal_r_ff && rsp_offset_green == cal_g_ff && rsp_offset_blue == cal_b_ff, "offsets drifted after calibration")

endmodule

bind rgb_color_calibrate_classify_top rgbcc_checker u_rgbcc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_was_calibration (rsp_was_calibration),
   .rsp_offset_red      (rsp_offset_red),
   .rsp_offset_green    (rsp_offset_green),
   .rsp_offset_blue     (rsp_offset_blue),
   .rsp_scaled_red      (rsp_scaled_red)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int N_COLORS        = 6;
   localparam int N_DIRECTED      = 18;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 220;
   localparam int DRAIN_CYCLES    = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam logic [rgbcc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

   // one result word, as the block reports it
   typedef struct packed {
      logic                           cal;
      logic [rgbcc_pkg::OFS_W-1:0]    ofs_r;
      logic [rgbcc_pkg::OFS_W-1:0]    ofs_g;
      logic [rgbcc_pkg::OFS_W-1:0]    ofs_b;
      logic [rgbcc_pkg::SCL_W-1:0]    scl_r;
      logic [rgbcc_pkg::SCL_W-1:0]    scl_g;
      logic [rgbcc_pkg::SCL_W-1:0]    scl_b;
      logic [N_COLORS-1:0]            mask;
   } colour_result_type;

   // directed row: a reading, and the result where it is obvious
   typedef struct packed {
      logic [rgbcc_pkg::RAW_W-1:0] r;
      logic [rgbcc_pkg::RAW_W-1:0] g;
      logic [rgbcc_pkg::RAW_W-1:0] b;
      logic                        typed;
      colour_result_type           want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic [rgbcc_pkg::RAW_W-1:0] req_raw_red   = '0;
   logic [rgbcc_pkg::RAW_W-1:0] req_raw_green = '0;
   logic [rgbcc_pkg::RAW_W-1:0] req_raw_blue  = '0;

   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_was_calibration;
   logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_red;
   logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_green;
   logic signed [rgbcc_pkg::OFS_W-1:0] rsp_offset_blue;
   logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_red;
   logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_green;
   logic signed [rgbcc_pkg::SCL_W-1:0] rsp_scaled_blue;
   logic [N_COLORS-1:0]                rsp_match_mask;

   logic                        csr_we    = 1'b0;
   logic [rgbcc_pkg::IDX_W-1:0] csr_index = '0;
   logic [rgbcc_pkg::REF_W-1:0] csr_wdata = '0;

   rgb_color_calibrate_classify_top #(
      .NUM_COLORS (N_COLORS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_red         (req_raw_red),
      .req_raw_green       (req_raw_green),
      .req_raw_blue        (req_raw_blue),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_was_calibration (rsp_was_calibration),
      .rsp_offset_red      (rsp_offset_red),
      .rsp_offset_green    (rsp_offset_green),
      .rsp_offset_blue     (rsp_offset_blue),
      .rsp_scaled_red      (rsp_scaled_red),
      .rsp_scaled_green    (rsp_scaled_green),
      .rsp_scaled_blue     (rsp_scaled_blue),
      .rsp_match_mask      (rsp_match_mask),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // directed readings: white reference first, then extremes, colour hits, edges
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{10'd520,  10'd480,  10'd500,  1'b1,
        '{1'b1, -11'sd20, 11'sd20, 11'sd0, 10'sd0, 10'sd0, 10'sd0, '0}},
      '{10'd0,    10'd0,    10'd0,    1'b1,
        '{1'b0, -11'sd20, 11'sd20, 11'sd0, -10'sd4, 10'sd4, 10'sd0, '0}},
      '{10'd1023, 10'd1023, 10'd1023, 1'b1,
        '{1'b0, -11'sd20, 11'sd20, 11'sd0, 10'sd250, 10'sd259, 10'sd255, '0}},
      '{10'd1023, 10'd0,    10'd0,    1'b0, '0},
      '{10'd0,    10'd1023, 10'd0,    1'b0, '0},
      '{10'd0,    10'd0,    10'd1023, 1'b0, '0},
      '{10'h2AA,  10'h155,  10'h2AA,  1'b0, '0},
      '{10'h155,  10'h2AA,  10'h155,  1'b0, '0},
      '{10'd736,  10'd696,  10'd724,  1'b0, '0},
      '{10'd948,  10'd788,  10'd960,  1'b0, '0},
      '{10'd836,  10'd764,  10'd724,  1'b0, '0},
      '{10'd732,  10'd716,  10'd896,  1'b0, '0},
      '{10'd748,  10'd852,  10'd988,  1'b0, '0},
      '{10'd992,  10'd836,  10'd760,  1'b0, '0},
      '{10'd20,   10'd0,    10'd1,    1'b0, '0},
      // red just inside, just outside and at the lower edge of colour 0
      '{10'd763,  10'd695,  10'd723,  1'b0, '0},
      '{10'd767,  10'd695,  10'd723,  1'b0, '0},
      '{10'd702,  10'd695,  10'd723,  1'b0, '0}
   };

   // predictor state: calibration, offsets and a shadow of the registers
   bit                          calibrated_q;
   int                          white_ofs [3];
   logic [rgbcc_pkg::TOL_W-1:0] tol_reg;
   logic [rgbcc_pkg::REF_W-1:0] ref_colour [N_COLORS];

   colour_result_type predicted_results [$];
   int  mismatches    = 0;
   int  words_sent    = 0;
   int  words_checked = 0;
   int  colour_hits   = 0;
   int  multi_hits    = 0;
   int  idle_cycles   = 0;
   int  ready_hold    = 0;
   bit  no_idle       = 1'b0;

   // white balance on the first word, then scale and match
   function automatic colour_result_type classify_word(logic [rgbcc_pkg::RAW_W-1:0] r, g, b);
      colour_result_type res;
      int raw [3];
      int scl [3];
      int mean;
      int d;
      bit hit;
      res    = '0;
      raw[0] = int'(r);
      raw[1] = int'(g);
      raw[2] = int'(b);
      if (!calibrated_q) begin
         mean = (raw[0] + raw[1] + raw[2]) / 3;
         for (int c = 0; c < 3; c++) white_ofs[c] = mean - raw[c];
         calibrated_q = 1'b1;
         res.cal      = 1'b1;
      end else begin
         for (int c = 0; c < 3; c++) scl[c] = ((raw[c] + white_ofs[c]) * 255) / 1023;
         for (int i = 0; i < N_COLORS; i++) begin
            hit = 1'b1;
            for (int c = 0; c < 3; c++) begin
               d = scl[c] - int'(ref_colour[i][8*(2-c) +: rgbcc_pkg::CHAN_W]);
               if (d < 0) d = -d;
               if (d >= int'(tol_reg)) hit = 1'b0;
            end
            res.mask[i] = hit;
         end
         res.scl_r = rgbcc_pkg::SCL_W'(scl[0]);
         res.scl_g = rgbcc_pkg::SCL_W'(scl[1]);
         res.scl_b = rgbcc_pkg::SCL_W'(scl[2]);
      end
      res.ofs_r = rgbcc_pkg::OFS_W'(white_ofs[0]);
      res.ofs_g = rgbcc_pkg::OFS_W'(white_ofs[1]);
      res.ofs_b = rgbcc_pkg::OFS_W'(white_ofs[2]);
      return res;
   endfunction

   // mostly no gap, sometimes a few cycles, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 50) return 0;
      if (roll < 85) return int'($urandom_range(1, 3));
      if (roll < 97) return int'($urandom_range(4, 15));
      return int'($urandom_range(16, 40));
   endfunction

   // raw reading whose corrected, scaled value lands near tgt
   function automatic logic [rgbcc_pkg::RAW_W-1:0] aim_raw(int tgt, int ofs);
      int m;
      m = tgt * 4 + int'($urandom_range(0, 5)) - ofs;
      if (m < 0) m = 0;
      else if (m > 1023) m = 1023;
      return rgbcc_pkg::RAW_W'(m);
   endfunction

   task automatic field_cmp(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_word(colour_result_type want, colour_result_type got);
      field_cmp("was_calibration", int'(want.cal), int'(got.cal));
      field_cmp("offset_red", $signed(want.ofs_r), $signed(got.ofs_r));
      field_cmp("offset_green", $signed(want.ofs_g), $signed(got.ofs_g));
      field_cmp("offset_blue", $signed(want.ofs_b), $signed(got.ofs_b));
      field_cmp("scaled_red", $signed(want.scl_r), $signed(got.scl_r));
      field_cmp("scaled_green", $signed(want.scl_g), $signed(got.scl_g));
      field_cmp("scaled_blue", $signed(want.scl_b), $signed(got.scl_b));
      field_cmp("match_mask", int'(want.mask), int'(got.mask));
   endtask

   // present one word, hold it until taken, then log its prediction
   task automatic send_word(logic [rgbcc_pkg::RAW_W-1:0] r, g, b, bit typed,
                            colour_result_type want);
      int gap;
      colour_result_type pred;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_red   <= r;
      req_raw_green <= g;
      req_raw_blue  <= b;
      do @(posedge clock); while (!req_ready);
      pred = classify_word(r, g, b);
      predicted_results.push_back(typed ? want : pred);
      words_sent++;
   endtask

   // one register write per clock; caller drops csr_we after the batch
   task automatic write_reg(logic [rgbcc_pkg::IDX_W-1:0] idx,
                            logic [rgbcc_pkg::REF_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == rgbcc_pkg::REG_TOLERANCE)
         tol_reg = data[rgbcc_pkg::TOL_W-1:0];
      else if (idx >= rgbcc_pkg::REG_REF_COLOR_0 &&
               int'(idx - rgbcc_pkg::REG_REF_COLOR_0) < N_COLORS)
         ref_colour[idx - rgbcc_pkg::REG_REF_COLOR_0] = data;
   endtask

   task automatic drain_results();
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // receiver: bursts of ready with stalls of random length
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!rsp_ready || no_idle) begin
         rsp_ready  <= 1'b1;
         ready_hold <= int'($urandom_range(1, 12));
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= pick_gap();
      end
   end

   // result checker
   always @(posedge clock) begin
      colour_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.cal   = rsp_was_calibration;
         got.ofs_r = rsp_offset_red;
         got.ofs_g = rsp_offset_green;
         got.ofs_b = rsp_offset_blue;
         got.scl_r = rsp_scaled_red;
         got.scl_g = rsp_scaled_green;
         got.scl_b = rsp_scaled_blue;
         got.mask  = rsp_match_mask;
         if (predicted_results.size() == 0) begin
            $display("%0t: unexpected result word, mask %0h", $time, got.mask);
            mismatches++;
         end else begin
            check_word(predicted_results.pop_front(), got);
         end
         if (got.mask != '0) colour_hits++;
         if ($countones(got.mask) > 1) multi_hits++;
         words_checked++;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, predicted_results.size());
         $display("** rgb_color_calibrate_classify_top: FAILED **");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_type                row;
      logic [rgbcc_pkg::RAW_W-1:0] raw [3];
      logic [rgbcc_pkg::REF_W-1:0] colour;
      logic [rgbcc_pkg::REF_W-1:0] prev;
      int                          tol;
      int                          jt;
      int                          k;
      int                          ch;

      calibrated_q = 1'b0;
      for (int c = 0; c < 3; c++) white_ofs[c] = 0;
      tol_reg = rgbcc_pkg::TOL_RESET;
      for (int i = 0; i < N_COLORS; i++) ref_colour[i] = rgbcc_pkg::REF_RESET[i];
      prev = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset register values
      for (int n = 0; n < N_DIRECTED; n++) begin
         row = directed_rows[n];
         send_word(row.r, row.g, row.b, row.typed, row.want);
      end
      req_valid <= 1'b0;

      // random part, one register setting per phase
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         if (p == 0) tol = 0;
         else if (p == 1) tol = 255;
         else if (p == 3) tol = 1;
         else tol = int'($urandom_range(2, 40));
         write_reg(rgbcc_pkg::REG_TOLERANCE, rgbcc_pkg::REF_W'(tol));
         for (int i = 0; i < N_COLORS; i++) begin
            colour = rgbcc_pkg::REF_W'($urandom);
            if (p == 1 && i == 0) begin
               colour = '0;
            end else if (p == 1 && i == 1) begin
               colour = '1;
            end else if (i > 0 && $urandom_range(0, 2) == 0) begin
               // close neighbour of the previous colour, for overlapping matches
               for (int c = 0; c < 3; c++) begin
                  ch = int'(prev[8*c +: rgbcc_pkg::CHAN_W]) + int'($urandom_range(0, 12)) - 6;
                  if (ch < 0) ch = 0;
                  else if (ch > 255) ch = 255;
                  colour[8*c +: rgbcc_pkg::CHAN_W] = ch[7:0];
               end
            end
            write_reg(rgbcc_pkg::IDX_W'(int'(rgbcc_pkg::REG_REF_COLOR_0) + i), colour);
            prev = colour;
         end
         if (p == 1 || p == 5) write_reg(REG_UNUSED, rgbcc_pkg::REF_W'($urandom));
         csr_we  <= 1'b0;
         no_idle = (p == 4);

         jt = (tol > 40 ? 40 : tol) + 2;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) < 7) begin
               k = int'($urandom_range(0, N_COLORS - 1));
               for (int c = 0; c < 3; c++)
                  raw[c] = aim_raw(int'(ref_colour[k][8*(2-c) +: rgbcc_pkg::CHAN_W]) +
                                   int'($urandom_range(0, 2 * jt)) - jt, white_ofs[c]);
            end else begin
               for (int c = 0; c < 3; c++)
                  raw[c] = rgbcc_pkg::RAW_W'($urandom_range(0, 1023));
            end
            send_word(raw[0], raw[1], raw[2], 1'b0, '0);
         end
         req_valid <= 1'b0;
      end

      // wait for the last results, then a few quiet cycles
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d words over %0d register settings, %0d results checked.",
               words_sent, PHASES + 1, words_checked);
      $display("%0d results matched a colour, %0d matched several at once.",
               colour_hits, multi_hits);
      if (mismatches == 0)
         $display("** rgb_color_calibrate_classify_top: PASSED **");
      else
         $display("** rgb_color_calibrate_classify_top: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/rgbcc_pkg.sv
design/rgb_color_calibrate_classify_top.sv
design/rgbcc_checker.sv
dv/tb_top.sv
